FILE: design/kbrt_pkg.sv
// Shared types and constants for the keyboard report key event tracker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package kbrt_pkg;

	localparam int unsigned KeyW   = 8;
	localparam int unsigned NSlots = 3;
	localparam int unsigned CfgIdxW = 2;

	typedef logic [KeyW-1:0] key_t;
	typedef key_t [NSlots-1:0] slots_t;

	localparam key_t KEY_NONE      = 8'h00;
	localparam key_t KEY_BACKSPACE = 8'h50;
	localparam key_t KEY_CAPS      = 8'h53;
	localparam key_t KEY_SHIFT_L   = 8'h54;
	localparam key_t KEY_SHIFT_R   = 8'h55;
	localparam key_t KEY_ALT       = 8'h57;

	localparam key_t OVF_ONE_RST = 8'h01;
	localparam key_t OVF_TWO_RST = 8'h02;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_OVF_ONE = 2'd0,
		CFG_OVF_TWO = 2'd1
	} cfg_idx_t;

	// Per-report decode handed from the evaluator to the top level.
	typedef struct packed {
		logic [NSlots-1:0] mask;
		logic              shift;
		logic              alt;
		logic              bksp;
		logic              caps_hit;
		logic              overflow;
	} eval_t;

endpackage

FILE: design/kbrt_eval.sv
// Combinational decode of one keyboard report against the previous report.
// Depends on kbrt_pkg.
`timescale 1ns / 1ps

module kbrt_eval
	import kbrt_pkg::*;
(
	input  slots_t keys,
	input  slots_t tracked,
	input  logic   suppress,
	input  key_t   ovf_one,
	input  key_t   ovf_two,
	output eval_t  res
);

	logic [NSlots-1:0] is_ovf;
	logic [NSlots-1:0] is_mod;
	logic [NSlots-1:0] fresh;
	logic [NSlots-1:0] hit_shift;
	logic [NSlots-1:0] hit_alt;
	logic [NSlots-1:0] hit_bksp;
	logic [NSlots-1:0] hit_caps;

	always_comb begin
		for (int i = 0; i < NSlots; i++) begin
			hit_shift[i] = (keys[i] == KEY_SHIFT_L) || (keys[i] == KEY_SHIFT_R);
			hit_alt[i]   = (keys[i] == KEY_ALT);
			hit_bksp[i]  = (keys[i] == KEY_BACKSPACE);
			hit_caps[i]  = (keys[i] == KEY_CAPS);
			is_ovf[i]    = (keys[i] == ovf_one) || (keys[i] == ovf_two);
			is_mod[i]    = (keys[i] == KEY_NONE) || hit_shift[i] || hit_alt[i];
			fresh[i]     = (keys[i] != KEY_NONE) && !hit_bksp[i];
			for (int t = 0; t < NSlots; t++) begin
				if (tracked[t] == keys[i]) begin
					fresh[i] = 1'b0;
				end
			end
			// drop a repeat of a key already seen in an earlier slot
			for (int j = 0; j < i; j++) begin
				if (keys[j] == keys[i]) begin
					fresh[i] = 1'b0;
				end
			end
		end
		res.mask     = suppress ? '0 : fresh;
		res.shift    = |hit_shift;
		res.alt      = |hit_alt;
		res.bksp     = |hit_bksp;
		res.caps_hit = |hit_caps;
		res.overflow = (&is_ovf) && !(&is_mod);
	end

endmodule

FILE: design/keyboard_report_key_event_tracker_core.sv
// Top level of the keyboard report key event tracker.
// Depends on kbrt_pkg and kbrt_eval.
`timescale 1ns / 1ps
//
//  channel   direction  handshake               payload
//  in        sink       in_valid / in_stall     key_first..key_third, text_suppressed
//  out       source     out_valid / out_stall   new_key_mask, pressed_*, flags
//  cfg       sink       cfg_we                  cfg_index, cfg_data
//
// One report per cycle while in_stall is low; its result is loaded into the result register
// at the accept edge. Tracked keys and caps state update at the accept edge.
// in_stall is high only while a result is held and out_stall is high.
// Reset clears tracked keys, caps state and restores the overflow codes to 1 and 2.

module keyboard_report_key_event_tracker_core
	import kbrt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  key_t               key_first,
	input  key_t               key_second,
	input  key_t               key_third,
	input  logic               text_suppressed,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [NSlots-1:0]  new_key_mask,
	output key_t               pressed_first,
	output key_t               pressed_second,
	output key_t               pressed_third,
	output logic               shift_held,
	output logic               alt_held,
	output logic               caps_lock_on,
	output logic               bksp_held,
	output logic               rollover_overflow,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  key_t               cfg_data
);

	key_t   ovf_one_q;
	key_t   ovf_two_q;
	slots_t tracked_q;
	logic   caps_held_q;
	logic   caps_state_q;
	logic   valid_s1;
	slots_t keys;
	eval_t  ev;
	logic   accept;
	logic   caps_next;

	assign keys = {key_third, key_second, key_first};
	assign in_stall = valid_s1 && out_stall;
	assign accept = in_valid && !in_stall;
	assign caps_next = caps_state_q ^ (ev.caps_hit && !caps_held_q);

	kbrt_eval u_eval (
		.keys     (keys),
		.tracked  (tracked_q),
		.suppress (text_suppressed),
		.ovf_one  (ovf_one_q),
		.ovf_two  (ovf_two_q),
		.res      (ev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_one_q <= OVF_ONE_RST;
			ovf_two_q <= OVF_TWO_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_OVF_ONE: ovf_one_q <= cfg_data;
				CFG_OVF_TWO: ovf_two_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracked_q    <= '0;
			caps_held_q  <= 1'b0;
			caps_state_q <= 1'b0;
			valid_s1     <= 1'b0;
		end else begin
			if (accept) begin
				// backspace is never tracked
				for (int i = 0; i < NSlots; i++) begin
					tracked_q[i] <= (keys[i] == KEY_BACKSPACE) ? KEY_NONE : keys[i];
				end
				caps_held_q  <= ev.caps_hit;
				caps_state_q <= caps_next;
				valid_s1     <= 1'b1;
			end else if (!out_stall) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// result word: load on accept, hold otherwise
	always_ff @(posedge clk) begin
		if (accept) begin
			new_key_mask      <= ev.mask;
			pressed_first     <= key_first;
			pressed_second    <= key_second;
			pressed_third     <= key_third;
			shift_held        <= ev.shift;
			alt_held          <= ev.alt;
			caps_lock_on      <= caps_next;
			bksp_held         <= ev.bksp;
			rollover_overflow <= ev.overflow;
		end
	end

	assign out_valid = valid_s1;

endmodule

FILE: design/kbrt_checker.sv
// Port-level checks for the keyboard report key event tracker, bound to the top.
// Depends on kbrt_pkg.
`timescale 1ns / 1ps

module kbrt_checker
	import kbrt_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input key_t               key_first,
	input key_t               key_second,
	input logic               out_valid,
	input logic               out_stall,
	input logic [NSlots-1:0]  new_key_mask,
	input key_t               pressed_first,
	input key_t               pressed_second,
	input key_t               pressed_third,
	input logic               shift_held
);

	// a held word keeps its keycodes
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pressed_first)
			&& $stable(pressed_second) && $stable(pressed_third))
		else $error("held result word changed");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid && pressed_first == $past(key_first)
			&& pressed_second == $past(key_second))
		else $error("accepted report gave no matching result");

	// second slot is only new if it differs from the first and is a real key
	a_mask_second: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && new_key_mask[1] |-> pressed_second != pressed_first
			&& pressed_second != KEY_NONE && pressed_second != KEY_BACKSPACE)
		else $error("second slot flagged new wrongly");

	a_shift: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && shift_held |-> pressed_first == KEY_SHIFT_L
			|| pressed_first == KEY_SHIFT_R || pressed_second == KEY_SHIFT_L
			|| pressed_second == KEY_SHIFT_R || pressed_third == KEY_SHIFT_L
			|| pressed_third == KEY_SHIFT_R)
		else $error("shift flagged without a shift key");

endmodule

bind keyboard_report_key_event_tracker_core kbrt_checker u_kbrt_checker (.*);

FILE: verif/keyboard_report_key_event_tracker_core_tb.sv
// Self-checking bench for keyboard_report_key_event_tracker_core: poll reports go in,
// each result word is checked against a local model of key tracking and caps lock.
// Depends on kbrt_pkg and the design sources only.
`timescale 1ns / 1ps

module keyboard_report_key_event_tracker_core_tb;
	import kbrt_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 2'd3;

	typedef struct packed {
		logic [NSlots-1:0] mask;
		key_t              first;
		key_t              second;
		key_t              third;
		logic              shift;
		logic              alt;
		logic              caps;
		logic              bksp;
		logic              ovf;
	} report_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	key_t               key_first;
	key_t               key_second;
	key_t               key_third;
	logic               text_suppressed;
	logic               out_valid;
	logic               out_stall;
	logic [NSlots-1:0]  new_key_mask;
	key_t               pressed_first;
	key_t               pressed_second;
	key_t               pressed_third;
	logic               shift_held;
	logic               alt_held;
	logic               caps_lock_on;
	logic               bksp_held;
	logic               rollover_overflow;
	logic               cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	key_t               cfg_data;

	// model state
	key_t tracked_prev [NSlots];
	logic caps_down_prev;
	logic caps_on_model;
	key_t ovf_code_a;
	key_t ovf_code_b;
	key_t last_sent [NSlots];

	report_result_t expected_reports [$];
	report_result_t oldest_report;
	int             errors;
	int             idle_cycles;
	bit             quiet_mode;
	int             hold_req;
	int             hold_left;
	int             stall_left;

	keyboard_report_key_event_tracker_core dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic report_result_t predict_report(key_t a, key_t b, key_t c, logic ts);
		key_t           k [NSlots];
		report_result_t r;
		logic           all_ovf;
		logic           all_mod;
		logic           caps_seen;
		logic           fresh;
		k = '{a, b, c};
		r = '0;
		all_ovf = 1'b1;
		all_mod = 1'b1;
		caps_seen = 1'b0;
		for (int i = 0; i < NSlots; i++) begin
			if (k[i] == KEY_SHIFT_L || k[i] == KEY_SHIFT_R)
				r.shift = 1'b1;
			if (k[i] == KEY_ALT)
				r.alt = 1'b1;
			if (k[i] == KEY_BACKSPACE)
				r.bksp = 1'b1;
			if (k[i] == KEY_CAPS)
				caps_seen = 1'b1;
			if (k[i] != ovf_code_a && k[i] != ovf_code_b)
				all_ovf = 1'b0;
			if (k[i] != KEY_NONE && k[i] != KEY_SHIFT_L && k[i] != KEY_SHIFT_R &&
				k[i] != KEY_ALT)
				all_mod = 1'b0;
		end
		for (int i = 0; i < NSlots; i++) begin
			if (k[i] != KEY_NONE && k[i] != KEY_BACKSPACE) begin
				fresh = !(k[i] == tracked_prev[0] || k[i] == tracked_prev[1] ||
					k[i] == tracked_prev[2]);
				// a repeat within the report only counts at its first slot
				for (int j = 0; j < i; j++)
					if (k[j] == k[i])
						fresh = 1'b0;
				r.mask[i] = fresh;
			end
		end
		if (ts)
			r.mask = '0;
		for (int i = 0; i < NSlots; i++)
			tracked_prev[i] = (k[i] == KEY_BACKSPACE) ? KEY_NONE : k[i];
		if (caps_seen && !caps_down_prev)
			caps_on_model = ~caps_on_model;
		caps_down_prev = caps_seen;
		r.caps = caps_on_model;
		r.first = a;
		r.second = b;
		r.third = c;
		r.ovf = all_ovf && !all_mod;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet_mode || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// Called at a falling edge; returns at a falling edge.
	task automatic send_report(key_t a, key_t b, key_t c, logic ts);
		int gap;
		in_valid <= 1'b1;
		key_first <= a;
		key_second <= b;
		key_third <= c;
		text_suppressed <= ts;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_reports.push_back(predict_report(a, b, c, ts));
		last_sent = '{a, b, c};
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Drop valid, then wait until every expected word has come back.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (expected_reports.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	// Write only while nothing is in flight.
	task automatic set_register(logic [CfgIdxW-1:0] idx, key_t val);
		wait_for_results();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == CFG_OVF_ONE)
			ovf_code_a = val;
		else if (idx == CFG_OVF_TWO)
			ovf_code_b = val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic key_t pick_modifier();
		case ($urandom_range(0, 4))
			0: return KEY_BACKSPACE;
			1: return KEY_CAPS;
			2: return KEY_SHIFT_L;
			3: return KEY_SHIFT_R;
			default: return KEY_ALT;
		endcase
	endfunction

	function automatic key_t pick_code();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20)
			return 8'h00;
		if (r < 40)
			return 8'hFF;
		if (r < 60)
			return pick_modifier();
		return key_t'($urandom_range(0, 255));
	endfunction

	task automatic send_random_report();
		key_t k [NSlots];
		int   r;
		int   shape;
		shape = $urandom_range(0, 99);
		for (int i = 0; i < NSlots; i++) begin
			r = $urandom_range(0, 99);
			if (shape < 8) begin
				// noise
				k[i] = key_t'($urandom_range(0, 255));
			end else if (shape < 16) begin
				// rollover-style report
				if (r < 70)
					k[i] = r[0] ? ovf_code_a : ovf_code_b;
				else if (r < 85)
					k[i] = KEY_NONE;
				else
					k[i] = pick_modifier();
			end else if (r < 32) begin
				// key still held, possibly moved to another slot
				k[i] = last_sent[$urandom_range(0, NSlots - 1)];
			end else if (r < 46) begin
				k[i] = KEY_NONE;
			end else if (r < 62) begin
				k[i] = pick_modifier();
			end else if (r < 68) begin
				k[i] = r[0] ? ovf_code_a : ovf_code_b;
			end else if (r < 76 && i > 0) begin
				k[i] = k[$urandom_range(0, i - 1)];
			end else begin
				k[i] = key_t'($urandom_range(0, 255));
			end
		end
		send_report(k[0], k[1], k[2], $urandom_range(0, 4) == 0);
	endtask

	task automatic test_directed_reports();
		send_report(KEY_NONE, KEY_NONE, KEY_NONE, 1'b0);
		send_report(8'h04, 8'h05, 8'h06, 1'b0);
		send_report(8'h04, 8'h05, 8'h06, 1'b0);
		send_report(8'h06, 8'h04, 8'h07, 1'b0);
		send_report(8'h08, 8'h08, 8'h09, 1'b0);
		send_report(8'hFF, 8'hFF, 8'hFF, 1'b1);
		send_report(8'hFF, 8'h80, 8'h7F, 1'b0);
		send_report(KEY_BACKSPACE, KEY_BACKSPACE, 8'h11, 1'b0);
		send_report(KEY_BACKSPACE, KEY_NONE, KEY_NONE, 1'b0);
		send_report(KEY_SHIFT_L, KEY_NONE, KEY_NONE, 1'b0);
		send_report(KEY_SHIFT_R, KEY_ALT, KEY_NONE, 1'b0);
		send_report(KEY_CAPS, KEY_NONE, KEY_NONE, 1'b0);
		send_report(KEY_CAPS, KEY_SHIFT_L, KEY_NONE, 1'b0);
		send_report(KEY_NONE, KEY_NONE, KEY_NONE, 1'b0);
		send_report(KEY_NONE, KEY_CAPS, KEY_NONE, 1'b1);
		send_report(OVF_ONE_RST, OVF_TWO_RST, OVF_ONE_RST, 1'b0);
		send_report(OVF_ONE_RST, OVF_TWO_RST, KEY_NONE, 1'b0);
		send_report(OVF_TWO_RST, OVF_TWO_RST, OVF_TWO_RST, 1'b0);
		send_report(OVF_ONE_RST, KEY_SHIFT_L, OVF_TWO_RST, 1'b0);
		send_report(KEY_SHIFT_R, KEY_SHIFT_R, KEY_SHIFT_R, 1'b0);
		send_report(8'hAA, KEY_SHIFT_R, 8'hAA, 1'b1);
		send_report(8'h55, 8'hAA, 8'h00, 1'b0);
	endtask

	task automatic test_overflow_codes();
		// overflow codes that are also modifier or empty codes
		set_register(CFG_OVF_ONE, KEY_SHIFT_L);
		set_register(CFG_OVF_TWO, KEY_NONE);
		send_report(KEY_SHIFT_L, KEY_NONE, KEY_NONE, 1'b0);
		send_report(KEY_NONE, KEY_NONE, KEY_NONE, 1'b0);
		send_report(KEY_SHIFT_L, KEY_SHIFT_L, KEY_SHIFT_L, 1'b0);
		set_register(CFG_OVF_ONE, 8'hFF);
		send_report(8'hFF, KEY_NONE, 8'hFF, 1'b0);
		send_report(KEY_NONE, KEY_NONE, KEY_NONE, 1'b0);
		// out-of-range indexes must leave both codes alone
		set_register(CFG_SPARE_LO, 8'h33);
		set_register(CFG_SPARE_HI, 8'h44);
		send_report(8'h33, 8'h33, 8'h33, 1'b0);
		send_report(8'h44, 8'h44, 8'h44, 1'b0);
		send_report(8'hFF, 8'hFF, KEY_NONE, 1'b0);
		set_register(CFG_OVF_ONE, KEY_ALT);
		set_register(CFG_OVF_TWO, KEY_CAPS);
		send_report(KEY_ALT, KEY_CAPS, KEY_CAPS, 1'b0);
		send_report(KEY_ALT, KEY_ALT, KEY_ALT, 1'b0);
		set_register(CFG_OVF_ONE, 8'h00);
		set_register(CFG_OVF_TWO, 8'hFF);
		send_report(8'hFF, 8'hFF, 8'hFF, 1'b0);
		send_report(KEY_NONE, 8'hFF, KEY_NONE, 1'b0);
		set_register(CFG_OVF_ONE, OVF_ONE_RST);
		set_register(CFG_OVF_TWO, OVF_TWO_RST);
	endtask

	task automatic test_random_reports();
		for (int phase = 0; phase < 8; phase++) begin
			set_register(CFG_OVF_ONE, pick_code());
			set_register(CFG_OVF_TWO, pick_code());
			if ($urandom_range(0, 3) == 0)
				set_register($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, pick_code());
			quiet_mode = (phase == 3);
			repeat (190) send_random_report();
			quiet_mode = 1'b0;
		end
	endtask

	task automatic test_backpressure();
		// long receiver hold-off while reports keep coming
		quiet_mode = 1'b1;
		hold_req = 90;
		repeat (30) send_random_report();
		quiet_mode = 1'b0;
		repeat (20) send_random_report();
		// pause the sender until everything is back
		wait_for_results();
		repeat (20) send_random_report();
	endtask

	// receiver: random stall bursts, mostly short
	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (quiet_mode) begin
			out_stall <= 1'b0;
		end else begin
			if (stall_left == 0) begin
				case ($urandom_range(0, 99)) inside
					[0:74]:  stall_left = 0;
					[75:94]: stall_left = $urandom_range(1, 3);
					default: stall_left = $urandom_range(8, 40);
				endcase
			end
			out_stall <= (stall_left > 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	task automatic compare_field(string field, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_reports.size() == 0) begin
				$display("%0t: result word with nothing expected", $time);
				errors++;
			end else begin
				oldest_report = expected_reports.pop_front();
				compare_field("new_key_mask", 8'(oldest_report.mask), 8'(new_key_mask));
				compare_field("pressed_first", oldest_report.first, pressed_first);
				compare_field("pressed_second", oldest_report.second, pressed_second);
				compare_field("pressed_third", oldest_report.third, pressed_third);
				compare_field("shift_held", 8'(oldest_report.shift), 8'(shift_held));
				compare_field("alt_held", 8'(oldest_report.alt), 8'(alt_held));
				compare_field("caps_lock_on", 8'(oldest_report.caps), 8'(caps_lock_on));
				compare_field("bksp_held", 8'(oldest_report.bksp), 8'(bksp_held));
				compare_field("rollover_overflow", 8'(oldest_report.ovf),
					8'(rollover_overflow));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
			$display("[keyboard_report_key_event_tracker_core] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		key_first = KEY_NONE;
		key_second = KEY_NONE;
		key_third = KEY_NONE;
		text_suppressed = 1'b0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_OVF_ONE;
		cfg_data = '0;
		errors = 0;
		idle_cycles = 0;
		quiet_mode = 1'b0;
		hold_req = 0;
		hold_left = 0;
		stall_left = 0;
		tracked_prev = '{KEY_NONE, KEY_NONE, KEY_NONE};
		last_sent = '{KEY_NONE, KEY_NONE, KEY_NONE};
		caps_down_prev = 1'b0;
		caps_on_model = 1'b0;
		ovf_code_a = OVF_ONE_RST;
		ovf_code_b = OVF_TWO_RST;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_reports();
		test_overflow_codes();
		test_backpressure();
		test_random_reports();

		wait_for_results();
		repeat (8) @(negedge clk);
		if (errors == 0)
			$display("[keyboard_report_key_event_tracker_core] OK");
		else
			$display("[keyboard_report_key_event_tracker_core] ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
design/kbrt_pkg.sv
design/kbrt_eval.sv
design/keyboard_report_key_event_tracker_core.sv
design/kbrt_checker.sv
verif/keyboard_report_key_event_tracker_core_tb.sv
